/* src/cct_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cct_pkg: shared types and constants of the canonical code table
// Transaction payloads, command encoding between the front and back end,
// and the layout of one table entry.
// ----------------------------------------------------------------------------
package cct_pkg;

   localparam int SYM_W       = 10;
   localparam int IN_LEN_W    = 8;
   localparam int LEN_W       = 7;
   localparam int CODE_W      = 64;
   localparam int EPOCH_W     = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      FN_CLEAR  = 2'd0,
      FN_ADD    = 2'd1,
      FN_LOOKUP = 2'd2,
      FN_NOP    = 2'd3
   } cct_func_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_TOO_LONG   = 2'd1,
      ST_DECREASED  = 2'd2,
      ST_UNASSIGNED = 2'd3
   } cct_status_type;

   // work handed from the front end to the back end
   typedef enum logic [1:0] {
      CMD_ECHO  = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cct_cmd_kind_type;

   typedef struct packed {
      cct_func_type      func;
      logic [SYM_W-1:0]  symbol;
      logic [IN_LEN_W-1:0] length;
   } cct_req_type;

   typedef struct packed {
      logic [SYM_W-1:0]  symbol_out;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  code_length;
      cct_status_type    status;
   } cct_rsp_type;

   typedef struct packed {
      cct_cmd_kind_type  kind;
      logic [SYM_W-1:0]  symbol;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  length;
      cct_status_type    status;
   } cct_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } cct_qstat_type;

   // one table word; tag zero never matches the live epoch
   typedef struct packed {
      logic [EPOCH_W-1:0] tag;
      logic [LEN_W-1:0]   length;
      logic [CODE_W-1:0]  code;
   } cct_entry_type;

endpackage

/* src/canonical_code_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canonical_code_table: canonical prefix-code builder with lookup
// Assigns canonical codes to symbols added in nondecreasing length order
// and answers lookups by symbol.
// ----------------------------------------------------------------------------
//  channel   ports                         handshake
//  request   start, busy, req_item         taken when start high, busy low
//  result    rsp_valid, rsp_item           one-cycle strobe, never stalled
//
//  One transaction is taken per cycle while busy is low; its result strobes
//  once it has passed the queue, the registered table read and the
//  result register. Busy rises when the four-entry command queue is full.
//  After reset a tag clearing sweep over every entry holds busy high; the
//  same sweep runs again on every 255th clear, once the entry tags run out.
// ----------------------------------------------------------------------------
module canonical_code_table #(
   parameter int SYMBOLS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  cct_pkg::cct_req_type req_item,
   output logic                 rsp_valid,
   output cct_pkg::cct_rsp_type rsp_item
);

   logic                   accept;
   logic                   push;
   logic                   pop;
   logic                   sweeping;
   cct_pkg::cct_cmd_type   push_cmd;
   cct_pkg::cct_cmd_type   head_cmd;
   cct_pkg::cct_qstat_type q_stat;

   assign busy   = q_stat.full || sweeping;
   assign accept = start && !busy;

   cct_front #(
      .SYMBOLS (SYMBOLS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_item (req_item),
      .push     (push),
      .cmd      (push_cmd)
   );

   cct_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .stat     (q_stat)
   );

   cct_back #(
      .SYMBOLS (SYMBOLS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_cmd  (head_cmd),
      .q_stat    (q_stat),
      .pop       (pop),
      .sweeping  (sweeping),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // no push into a full queue
   assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full)
      else $error("command pushed into full queue");

   // failed transactions carry no code
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status != cct_pkg::ST_OK)) |->
         ((rsp_item.code == '0) && (rsp_item.code_length == '0)))
      else $error("error result carries a code");

   // code lengths never exceed the code width
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.code_length <= cct_pkg::LEN_W'(cct_pkg::CODE_W)))
      else $error("result code length out of range");

   // the clearing sweep holds requests off straight after reset
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> busy)
      else $error("request side open during clearing sweep");

endmodule

/* src/cct_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cct_front: request classification and running code
// Checks each accepted transaction, keeps the running canonical code and
// the previous length, and turns the request into a back-end command.
// ----------------------------------------------------------------------------
module cct_front #(
   parameter int SYMBOLS = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  cct_pkg::cct_req_type req_item,
   output logic                push,
   output cct_pkg::cct_cmd_type cmd
);

   logic [cct_pkg::CODE_W-1:0] running_ff, running_in;
   logic [cct_pkg::LEN_W-1:0]  prev_len_ff, prev_len_in;
   logic                       any_added_ff, any_added_in;

   logic                       too_long;
   logic                       decreased;
   logic                       beyond;
   logic [cct_pkg::LEN_W-1:0]  len_short;
   logic [cct_pkg::LEN_W-1:0]  growth;
   logic [cct_pkg::CODE_W-1:0] shifted;

   // classify the request
   always_comb begin
      len_short = req_item.length[cct_pkg::LEN_W-1:0];
      too_long  = req_item.length > cct_pkg::IN_LEN_W'(cct_pkg::CODE_W);
      decreased = any_added_ff && (len_short < prev_len_ff);
      beyond    = 32'(req_item.symbol) >= 32'(SYMBOLS);
      growth    = len_short - prev_len_ff;
      // a growth of the full code width clears the code
      shifted   = growth[cct_pkg::LEN_W-1] ? '0 :
                  (running_ff << growth[cct_pkg::LEN_W-2:0]);
   end

   // build the command and the next running state
   always_comb begin
      push         = accept;
      running_in   = running_ff;
      prev_len_in  = prev_len_ff;
      any_added_in = any_added_ff;
      cmd.kind     = cct_pkg::CMD_ECHO;
      cmd.symbol   = req_item.symbol;
      cmd.code     = '0;
      cmd.length   = '0;
      cmd.status   = cct_pkg::ST_OK;
      case (req_item.func)
         cct_pkg::FN_CLEAR: begin
            cmd.kind = cct_pkg::CMD_CLEAR;
            if (accept) begin
               running_in   = '0;
               prev_len_in  = '0;
               any_added_in = 1'b0;
            end
         end
         cct_pkg::FN_ADD: begin
            if (too_long) begin
               cmd.status = cct_pkg::ST_TOO_LONG;
            end else if (decreased) begin
               cmd.status = cct_pkg::ST_DECREASED;
            end else if (beyond) begin
               cmd.status = cct_pkg::ST_UNASSIGNED;
            end else begin
               cmd.kind   = cct_pkg::CMD_WRITE;
               cmd.code   = shifted;
               cmd.length = len_short;
               if (accept) begin
                  running_in   = shifted + cct_pkg::CODE_W'(1);
                  prev_len_in  = len_short;
                  any_added_in = 1'b1;
               end
            end
         end
         cct_pkg::FN_LOOKUP: begin
            if (beyond) begin
               cmd.status = cct_pkg::ST_UNASSIGNED;
            end else begin
               cmd.kind = cct_pkg::CMD_READ;
            end
         end
         default: begin
            cmd.kind = cct_pkg::CMD_ECHO;
         end
      endcase
   end

   // hold the running state
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= '0;
         prev_len_ff  <= '0;
         any_added_ff <= 1'b0;
      end else begin
         running_ff   <= running_in;
         prev_len_ff  <= prev_len_in;
         any_added_ff <= any_added_in;
      end
   end

endmodule

/* src/cct_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cct_queue: command queue between front and back end
// Small first-in first-out store of commands; the head is shown directly.
// ----------------------------------------------------------------------------
module cct_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cct_pkg::cct_cmd_type  push_cmd,
   input  logic                  pop,
   output cct_pkg::cct_cmd_type  head_cmd,
   output cct_pkg::cct_qstat_type stat
);

   cct_pkg::cct_cmd_type        entries_ff [cct_pkg::QUEUE_DEPTH];
   logic [cct_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [cct_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [cct_pkg::QPTR_W:0]    count_ff, count_in;

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + cct_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + cct_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (cct_pkg::QPTR_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (cct_pkg::QPTR_W + 1)'(1);
      end
      stat.full  = count_ff == (cct_pkg::QPTR_W + 1)'(cct_pkg::QUEUE_DEPTH);
      stat.empty = count_ff == '0;
      head_cmd   = entries_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store pushed commands
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* src/cct_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cct_back: table memory and result generation
// Executes queued commands against the code table, tracks the live epoch
// that marks valid entries, runs the tag clearing sweep and registers the
// result transaction.
// ----------------------------------------------------------------------------
module cct_back #(
   parameter int SYMBOLS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cct_pkg::cct_cmd_type   head_cmd,
   input  cct_pkg::cct_qstat_type q_stat,
   output logic                   pop,
   output logic                   sweeping,
   output logic                   rsp_valid,
   output cct_pkg::cct_rsp_type   rsp_item
);

   localparam int IDX_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SYMBOLS - 1);

   cct_pkg::cct_entry_type       mem_array [SYMBOLS];
   cct_pkg::cct_entry_type       rd_data_ff;
   cct_pkg::cct_entry_type       wr_data;
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;
   logic [IDX_W-1:0]             cmd_idx;

   logic                         sweep_ff, sweep_in;
   logic [IDX_W-1:0]             sweep_cnt_ff, sweep_cnt_in;
   logic [cct_pkg::EPOCH_W-1:0]  epoch_ff, epoch_in;

   logic                         stg_valid_ff;
   cct_pkg::cct_cmd_type         stg_cmd_ff;
   logic [cct_pkg::EPOCH_W-1:0]  stg_epoch_ff;

   logic                         rsp_valid_ff;
   cct_pkg::cct_rsp_type         rsp_ff, rsp_in;
   logic                         hit;

   // pop and memory port selection
   always_comb begin
      pop     = !sweep_ff && !q_stat.empty;
      cmd_idx = IDX_W'(head_cmd.symbol);
      wr_en   = sweep_ff || (pop && (head_cmd.kind == cct_pkg::CMD_WRITE));
      wr_addr = sweep_ff ? sweep_cnt_ff : cmd_idx;
      wr_data.tag    = sweep_ff ? '0 : epoch_ff;
      wr_data.length = head_cmd.length;
      wr_data.code   = head_cmd.code;
   end

   // table memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_array[cmd_idx];
   end

   // advance epoch and clearing sweep
   always_comb begin
      sweep_in     = sweep_ff;
      sweep_cnt_in = sweep_cnt_ff;
      epoch_in     = epoch_ff;
      if (sweep_ff) begin
         sweep_cnt_in = sweep_cnt_ff + IDX_W'(1);
         if (sweep_cnt_ff == LAST_IDX) begin
            sweep_in     = 1'b0;
            sweep_cnt_in = '0;
         end
      end else if (pop && (head_cmd.kind == cct_pkg::CMD_CLEAR)) begin
         // out of fresh tags: wipe every tag, then restart at one
         if (epoch_ff == '1) begin
            sweep_in = 1'b1;
            epoch_in = cct_pkg::EPOCH_W'(1);
         end else begin
            epoch_in = epoch_ff + cct_pkg::EPOCH_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= 1'b1;
         sweep_cnt_ff <= '0;
         epoch_ff     <= cct_pkg::EPOCH_W'(1);
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sweep_ff     <= sweep_in;
         sweep_cnt_ff <= sweep_cnt_in;
         epoch_ff     <= epoch_in;
         stg_valid_ff <= pop;
         rsp_valid_ff <= stg_valid_ff;
      end
   end

   // hold the command beside the memory read
   always_ff @(posedge clock) begin
      stg_cmd_ff   <= head_cmd;
      stg_epoch_ff <= epoch_ff;
      rsp_ff       <= rsp_in;
   end

   // form the result
   always_comb begin
      hit                = rd_data_ff.tag == stg_epoch_ff;
      rsp_in.symbol_out  = stg_cmd_ff.symbol;
      rsp_in.code        = stg_cmd_ff.code;
      rsp_in.code_length = stg_cmd_ff.length;
      rsp_in.status      = stg_cmd_ff.status;
      if (stg_cmd_ff.kind == cct_pkg::CMD_READ) begin
         if (hit) begin
            rsp_in.code        = rd_data_ff.code;
            rsp_in.code_length = rd_data_ff.length;
            rsp_in.status      = cct_pkg::ST_OK;
         end else begin
            rsp_in.code        = '0;
            rsp_in.code_length = '0;
            rsp_in.status      = cct_pkg::ST_UNASSIGNED;
         end
      end
   end

   assign sweeping  = sweep_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
